### hdl/bipz_pkg.sv
// Shared constants and types of the periodic-z bilinear interpolation unit.
`default_nettype none

package bipz_pkg;

    // Grid geometry; both dimensions are powers of two, so x*GRID_Z+z is a concatenation.
    localparam int GRID_X      = 64;
    localparam int GRID_Z      = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;

    localparam int XW          = $clog2(GRID_X);
    localparam int ZW          = $clog2(GRID_Z);
    localparam int ADDR_W      = XW + ZW;
    localparam int STORE_DEPTH = GRID_X * GRID_Z;

    // Field widths of the channels
    localparam int LOAD_IDX_W  = 6;
    localparam int SAMPLE_IN_W = 16;
    localparam int POS_W       = 16;
    localparam int VALUE_W     = 16;

    localparam int IX_W        = POS_W - FRAC_BITS;
    localparam int FACT_W      = FRAC_BITS + 1;
    localparam int WGT_W       = 2 * FRAC_BITS + 1;
    localparam int PROD_W      = SAMPLE_BITS + WGT_W + 1;
    localparam int ACC_W       = PROD_W;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int HALF        = 1 << (2 * FRAC_BITS - 1);

    localparam int READS       = 4;
    localparam int CNT_W       = $clog2(READS);

    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    // req_type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_CLIP
    } op_t;

    // Flags that travel with one memory read through the blend pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic clip;
    } bipz_ctrl_t;

endpackage

`default_nettype wire

### hdl/bipz_if.sv
// Request and response channel interfaces of the interpolation unit.
`default_nettype none

interface bipz_req_if import bipz_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [LOAD_IDX_W-1:0]         load_x;
    logic [LOAD_IDX_W-1:0]         load_z;
    logic signed [SAMPLE_IN_W-1:0] sample;
    logic signed [POS_W-1:0]       pos_x;
    logic signed [POS_W-1:0]       pos_z;

    modport source (output valid, req_type, load_x, load_z, sample, pos_x, pos_z,
                    input ready);
    modport sink   (input valid, req_type, load_x, load_z, sample, pos_x, pos_z,
                    output ready);
endinterface

interface bipz_rsp_if import bipz_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      out_of_range;

    modport source (output valid, value, out_of_range, input ready);
    modport sink   (input valid, value, out_of_range, output ready);
endinterface

`default_nettype wire

### hdl/bipz_blend.sv
// Weight multiply, four-term accumulate and rounding of one interpolation.
`default_nettype none

module bipz_blend import bipz_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bipz_ctrl_t                ctrl,
    input  wire logic [WGT_W-1:0]          weight,
    input  wire logic [SAMPLE_BITS-1:0]    rdata,
    output logic                           res_valid,
    output logic signed [VALUE_W-1:0]      res_value,
    output logic                           res_clip
);

    bipz_ctrl_t               ctrl2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  sum_next;
    logic                     res_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                     clip_reg;

    assign prod_next = $signed(rdata) * $signed({1'b0, weight});

    // rounding offset enters with the first term
    assign sum_next = (ctrl2_reg.first ? ACC_W'(HALF) : acc_reg) + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl2_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl2_reg     <= ctrl;
            res_valid_reg <= ctrl2_reg.valid && ctrl2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl2_reg.valid)
        begin
            acc_reg <= sum_next;
        end
        if (ctrl2_reg.valid && ctrl2_reg.last)
        begin
            clip_reg  <= ctrl2_reg.clip;
            value_reg <= ctrl2_reg.clip ? '0 : VALUE_W'(sum_next >>> (2 * FRAC_BITS));
        end
    end

    assign res_valid = res_valid_reg;
    assign res_value = value_reg;
    assign res_clip  = clip_reg;

    // a clipped query never spans more than one slot
    a_clip_single: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl2_reg.valid && ctrl2_reg.clip |-> ctrl2_reg.first && ctrl2_reg.last)
        else $error("clipped query spans several slots");

    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl2_reg.valid && ctrl2_reg.last |=> res_valid)
        else $error("finished sum did not reach the result register");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(ctrl2_reg.valid && ctrl2_reg.last))
        else $error("result without a finished sum");

endmodule

`default_nettype wire

### hdl/bilinear_interp_periodic_z_unit.sv
// Top level of the periodic-z bilinear interpolation unit.
// Channels: req (sink) carries load and query items, rsp (source) carries one
// result item per query; an item moves when valid and ready are both high.
// A load writes one sample of the 64 x 64 plane and gives no result; loads
// outside the plane are dropped. A query floors pos_x/pos_z (8 fraction bits),
// reads four neighbors and returns the rounded weighted sum; z wraps, and an x
// corner outside 0..GRID_X-2 gives value 0 with out_of_range set.
// Issue: an in-range query holds the single-port sample memory for four reads,
// a load or an out-of-range query for a single access; the next item is taken
// in the cycle the current one issues its last access, while a queue slot is unreserved.
// A query's reads pass the memory-stage registers and the blend's product and
// result registers on their way to the output queue.
// Results wait in a 4-entry output queue; a query is accepted only while a
// queue slot is reserved for it, so a stalled receiver stops intake after at
// most 4 pending results and nothing is lost.
// Reset clears all control state; the sample memory keeps no reset value and
// every entry must be loaded before a query reads it.
`default_nettype none

module bilinear_interp_periodic_z_unit import bipz_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bipz_req_if.sink  req,
    bipz_rsp_if.source rsp
);

    // issue stage
    logic                      busy_reg, busy_next;
    op_t                       op_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [XW-1:0]             x0_reg;
    logic [ZW-1:0]             z0_reg;
    logic [ZW-1:0]             z1_reg;
    logic [FRAC_BITS-1:0]      tx_reg;
    logic [FRAC_BITS-1:0]      tz_reg;
    logic [ADDR_W-1:0]         ld_addr_reg;
    logic [SAMPLE_BITS-1:0]    ld_data_reg;
    logic                      ld_ok_reg;

    logic                      accept;
    logic                      done_now;
    logic signed [IX_W-1:0]    ix;
    logic signed [IX_W-1:0]    iz;
    logic [ZW-1:0]             z0_in;
    logic                      clip_in;
    logic                      ld_ok_in;

    logic [FACT_W-1:0]         fx;
    logic [FACT_W-1:0]         fz;
    logic [WGT_W-1:0]          w_next;
    logic [XW-1:0]             rd_x;
    logic [ZW-1:0]             rd_z;
    logic [ADDR_W-1:0]         mem_addr;
    logic                      mem_we;
    bipz_ctrl_t                ctrl_next;

    // memory stage
    logic [SAMPLE_BITS-1:0]    mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0]    rdata_reg;
    logic [WGT_W-1:0]          w_reg;
    bipz_ctrl_t                ctrl_reg;

    // blend results and output queue
    logic                      res_valid;
    logic signed [VALUE_W-1:0] res_value;
    logic                      res_clip;
    logic signed [VALUE_W-1:0] q_value [OUT_DEPTH];
    logic                      q_clip  [OUT_DEPTH];
    logic [OPTR_W-1:0]         wr_ptr_reg;
    logic [OPTR_W-1:0]         rd_ptr_reg;
    logic [OCNT_W-1:0]         q_cnt_reg;
    logic [OCNT_W-1:0]         credit_reg;
    logic                      pop;
    logic                      take_query;

    // ---------------- intake ----------------
    assign done_now = busy_reg && ((op_reg != OP_QUERY) || (cnt_reg == CNT_W'(READS - 1)));
    assign req.ready = (!busy_reg || done_now) && (credit_reg < OCNT_W'(OUT_DEPTH));
    assign accept = req.valid && req.ready;
    assign take_query = accept && (req.req_type == REQ_QUERY);

    assign ix = IX_W'(req.pos_x >>> FRAC_BITS);
    assign iz = IX_W'(req.pos_z >>> FRAC_BITS);
    assign z0_in = ZW'(iz);     // power-of-two period: wrap is the low bits
    assign clip_in = (ix < 0) || (int'(ix) > GRID_X - 2);
    assign ld_ok_in = (int'(req.load_x) < GRID_X) && (int'(req.load_z) < GRID_Z);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (done_now)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_LOAD;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (accept)
            begin
                if (req.req_type == REQ_LOAD)
                begin
                    op_reg <= OP_LOAD;
                end
                else if (clip_in)
                begin
                    op_reg <= OP_CLIP;
                end
                else
                begin
                    op_reg <= OP_QUERY;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg      <= XW'(ix);
            z0_reg      <= z0_in;
            z1_reg      <= z0_in + ZW'(1);
            tx_reg      <= req.pos_x[FRAC_BITS-1:0];
            tz_reg      <= req.pos_z[FRAC_BITS-1:0];
            ld_addr_reg <= {XW'(req.load_x), ZW'(req.load_z)};
            ld_data_reg <= SAMPLE_BITS'(req.sample);
            ld_ok_reg   <= ld_ok_in;
        end
    end

    // ---------------- issue: one memory access per cycle ----------------
    // read order: (x0,z0) (x0+1,z0) (x0,z1) (x0+1,z1)
    assign fx     = cnt_reg[0] ? FACT_W'(tx_reg) : FACT_W'(ONE) - FACT_W'(tx_reg);
    assign fz     = cnt_reg[1] ? FACT_W'(tz_reg) : FACT_W'(ONE) - FACT_W'(tz_reg);
    assign w_next = WGT_W'(fx * fz);
    assign rd_x   = x0_reg + XW'(cnt_reg[0]);
    assign rd_z   = cnt_reg[1] ? z1_reg : z0_reg;

    assign mem_we   = busy_reg && (op_reg == OP_LOAD) && ld_ok_reg;
    assign mem_addr = (op_reg == OP_LOAD) ? ld_addr_reg : {rd_x, rd_z};

    always_comb
    begin
        ctrl_next.valid = busy_reg && (op_reg != OP_LOAD);
        ctrl_next.first = (cnt_reg == '0) || (op_reg == OP_CLIP);
        ctrl_next.last  = done_now;
        ctrl_next.clip  = (op_reg == OP_CLIP);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= ld_data_reg;
        end
        rdata_reg <= mem[mem_addr];
        w_reg     <= w_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    bipz_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_reg),
        .weight    (w_reg),
        .rdata     (rdata_reg),
        .res_valid (res_valid),
        .res_value (res_value),
        .res_clip  (res_clip)
    );

    // ---------------- output queue ----------------
    assign pop              = rsp.valid && rsp.ready;
    assign rsp.valid        = (q_cnt_reg != '0);
    assign rsp.value        = q_value[rd_ptr_reg];
    assign rsp.out_of_range = q_clip[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            q_value[wr_ptr_reg] <= res_value;
            q_clip[wr_ptr_reg]  <= res_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (res_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + OPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OPTR_W'(1);
            end
            q_cnt_reg  <= q_cnt_reg + OCNT_W'(res_valid) - OCNT_W'(pop);
            credit_reg <= credit_reg + OCNT_W'(take_query) - OCNT_W'(pop);
        end
    end

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= OCNT_W'(OUT_DEPTH))
        else $error("more queries in flight than queue slots");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (q_cnt_reg < OCNT_W'(OUT_DEPTH)) || pop)
        else $error("result pushed into a full queue");

    a_queue_covered: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= credit_reg)
        else $error("queued results exceed reserved slots");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take_query |=> busy_reg && (cnt_reg == '0))
        else $error("accepted query did not start issuing");

endmodule

`default_nettype wire
